/* hdl/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types and constants for the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam logic [7:0] PAD_CHAR        = 8'h3D;
	localparam int         OUT_FIFO_DEPTH  = 4;
	localparam int         JOB_SLOTS       = 4;

	typedef enum logic [1:0] {
		JOB_READ  = 2'd0,
		JOB_PAD   = 2'd1,
		JOB_WRITE = 2'd2
	} job_kind_t;

	// one unit of work for the table port: lookup, pad or table load
	typedef struct packed {
		job_kind_t   kind;
		logic [5:0]  idx;
		logic [7:0]  wdata;
		logic        last;
	} job_t;

endpackage

/* hdl/b64e_if.sv */
// ----------------------------------------------------------------------------
// b64e_if
// Valid/ready channels for the byte input and the character output.
// ----------------------------------------------------------------------------
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;
	logic       last_byte;
	logic [5:0] table_index;
	logic [7:0] table_char;

	modport source (output valid, req_type, data_byte, last_byte, table_index, table_char,
		input ready);
	modport sink (input valid, req_type, data_byte, last_byte, table_index, table_char,
		output ready);
endinterface

interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;

	modport source (output valid, out_char, out_last, input ready);
	modport sink (input valid, out_char, out_last, output ready);
endinterface

/* hdl/b64e_out_fifo.sv */
// ----------------------------------------------------------------------------
// b64e_out_fifo
// Small output queue that decouples the table pipeline from the sink.
// ----------------------------------------------------------------------------
module b64e_out_fifo #(
	parameter int DEPTH = b64e_pkg::OUT_FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [7:0]                 push_char,
	input  logic                       push_last,
	output logic [$clog2(DEPTH+1)-1:0] occupancy,
	b64e_char_if.source                chars
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [7:0]    char_mem [DEPTH];
	logic          last_mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign pop            = chars.valid && chars.ready;
	assign chars.valid    = (cnt_q != '0);
	assign chars.out_char = char_mem[rd_ptr_q];
	assign chars.out_last = last_mem[rd_ptr_q];
	assign occupancy      = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			char_mem[wr_ptr_q] <= push_char;
			last_mem[wr_ptr_q] <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with a loadable 64-entry alphabet.
// ----------------------------------------------------------------------------
// Each accepted transaction is split into jobs: a table load is one write job,
// a data byte gives one to four jobs (lookups and '=' pads). The alphabet RAM
// has a single port and serves one job per cycle while the output FIFO has
// room (write jobs do not wait for room), so a new item is taken only when no
// jobs remain or as the last job of the current item issues. A lookup result
// is registered in the read stage and then pushed into the output FIFO. Loads
// are applied in transaction order, so a load never changes characters of
// earlier bytes.
module base64_stream_encoder #(
	parameter int FIFO_DEPTH = b64e_pkg::OUT_FIFO_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	b64e_byte_if.sink bytes,
	b64e_char_if.source chars
);
	import b64e_pkg::*;

	localparam int CW = $clog2(FIFO_DEPTH+1);
	localparam int JW = $clog2(JOB_SLOTS+1);

	localparam logic [1:0] POS_1 = 2'd1;
	localparam logic [1:0] POS_2 = 2'd2;

	// group state
	logic [1:0] pos_q;
	logic [3:0] carry_q;

	// job buffer, drained from slot 0
	job_t       jobs_q [JOB_SLOTS];
	logic [JW-1:0] njobs_q;

	// expansion of the incoming transaction
	job_t       new_jobs [JOB_SLOTS];
	logic [JW-1:0] new_cnt;
	logic [1:0] new_pos;
	logic [3:0] new_carry;

	logic          accept;
	logic          issue;
	logic          room;
	logic [CW-1:0] occupancy;

	// alphabet RAM and read stage
	logic [7:0] alpha_mem [64];
	logic [7:0] rd_s1;
	logic       valid_s1;
	logic       pad_s1;
	logic       last_s1;

	assign room   = (occupancy + CW'(valid_s1)) < CW'(FIFO_DEPTH);
	assign issue  = (njobs_q != '0) && ((jobs_q[0].kind == JOB_WRITE) || room);
	assign bytes.ready = (njobs_q == '0) || ((njobs_q == JW'(1)) && issue);
	assign accept = bytes.valid && bytes.ready;

	always_comb begin
		job_t blank;
		blank = '{kind: JOB_PAD, idx: '0, wdata: '0, last: 1'b0};
		for (int i = 0; i < JOB_SLOTS; i++) begin
			new_jobs[i] = blank;
		end
		new_cnt   = JW'(1);
		new_pos   = pos_q;
		new_carry = carry_q;
		if (bytes.req_type) begin
			new_jobs[0] = '{kind: JOB_WRITE, idx: bytes.table_index,
				wdata: bytes.table_char, last: 1'b0};
		end else begin
			case (pos_q)
				POS_1: begin
					new_jobs[0] = '{kind: JOB_READ, idx: {carry_q[1:0], bytes.data_byte[7:4]},
						wdata: '0, last: 1'b0};
					if (bytes.last_byte) begin
						new_jobs[1] = '{kind: JOB_READ, idx: {bytes.data_byte[3:0], 2'b00},
							wdata: '0, last: 1'b0};
						new_jobs[2].last = 1'b1;
						new_cnt   = JW'(3);
						new_pos   = '0;
						new_carry = '0;
					end else begin
						new_pos   = POS_2;
						new_carry = bytes.data_byte[3:0];
					end
				end
				POS_2: begin
					new_jobs[0] = '{kind: JOB_READ, idx: {carry_q, bytes.data_byte[7:6]},
						wdata: '0, last: 1'b0};
					new_jobs[1] = '{kind: JOB_READ, idx: bytes.data_byte[5:0],
						wdata: '0, last: bytes.last_byte};
					new_cnt   = JW'(2);
					new_pos   = '0;
					new_carry = '0;
				end
				default: begin
					// position three is unreachable and behaves as zero
					new_jobs[0] = '{kind: JOB_READ, idx: bytes.data_byte[7:2],
						wdata: '0, last: 1'b0};
					if (bytes.last_byte) begin
						new_jobs[1] = '{kind: JOB_READ, idx: {bytes.data_byte[1:0], 4'b0000},
							wdata: '0, last: 1'b0};
						new_jobs[3].last = 1'b1;
						new_cnt   = JW'(4);
						new_pos   = '0;
						new_carry = '0;
					end else begin
						new_pos   = POS_1;
						new_carry = {2'b00, bytes.data_byte[1:0]};
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			carry_q  <= '0;
			njobs_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q   <= new_pos;
				carry_q <= new_carry;
				njobs_q <= new_cnt;
			end else if (issue) begin
				njobs_q <= njobs_q - 1'b1;
			end
			valid_s1 <= issue && (jobs_q[0].kind != JOB_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			jobs_q <= new_jobs;
		end else if (issue) begin
			for (int i = 0; i < JOB_SLOTS-1; i++) begin
				jobs_q[i] <= jobs_q[i+1];
			end
		end
		pad_s1  <= (jobs_q[0].kind == JOB_PAD);
		last_s1 <= jobs_q[0].last;
	end

	// single-port alphabet RAM, at most one job per cycle keeps load/lookup order
	always_ff @(posedge clk) begin
		if (issue && (jobs_q[0].kind == JOB_WRITE)) begin
			alpha_mem[jobs_q[0].idx] <= jobs_q[0].wdata;
		end
		rd_s1 <= alpha_mem[jobs_q[0].idx];
	end

	b64e_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_char (pad_s1 ? PAD_CHAR : rd_s1),
		.push_last (last_s1),
		.occupancy (occupancy),
		.chars     (chars)
	);

endmodule

/* tb/sv/tb_base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Self-checking bench for the base64 stream encoder. The whole alphabet is
// loaded first, then directed messages exercise every tail length and a table
// load in the middle of a message. Random messages with interleaved table
// loads follow. A behavioral encoder predicts each character, and the monitor
// compares it with the character that arrives at the output.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;
	import b64e_pkg::*;

	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	localparam logic [1:0] POS_START = 2'd0;
	localparam logic [1:0] POS_ONE   = 2'd1;
	localparam logic [1:0] POS_TWO   = 2'd2;

	localparam int RANDOM_ITEMS = 102;
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic       req_type;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [5:0] table_index;
		logic [7:0] table_char;
	} byte_req_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} b64_char_t;

	logic clk = 1'b0;
	logic arst_n;

	b64e_byte_if byte_ch();
	b64e_char_if char_ch();

	base64_stream_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.chars  (char_ch)
	);

	always #6 clk = ~clk;

	byte_req_t byte_queue[$];
	b64_char_t char_queue[$];

	// encoder state as seen from outside
	logic [7:0] alphabet[64];
	logic [1:0] grp_pos;
	logic [3:0] carry;

	int   total_items;
	int   items_taken;
	int   mismatches;
	int   cycle_count;
	logic byte_taken;

	function automatic byte_req_t mk_data(input logic [7:0] b, input logic last);
		byte_req_t r;
		r.req_type    = REQ_DATA;
		r.data_byte   = b;
		r.last_byte   = last;
		r.table_index = 6'($urandom_range(63));
		r.table_char  = 8'($urandom_range(255));
		return r;
	endfunction

	function automatic byte_req_t mk_load(input logic [5:0] idx, input logic [7:0] ch);
		byte_req_t r;
		r.req_type    = REQ_LOAD;
		r.data_byte   = 8'($urandom_range(255));
		r.last_byte   = 1'($urandom_range(1));
		r.table_index = idx;
		r.table_char  = ch;
		return r;
	endfunction

	function automatic logic [7:0] std_alphabet(input int idx);
		if (idx < 26)
			return 8'("A" + idx);
		else if (idx < 52)
			return 8'("a" + idx - 26);
		else if (idx < 62)
			return 8'("0" + idx - 52);
		else if (idx == 62)
			return 8'("+");
		return 8'("/");
	endfunction

	function automatic void push_char(input logic [7:0] ch, input logic last);
		b64_char_t c;
		c.ch   = ch;
		c.last = last;
		char_queue.push_back(c);
	endfunction

	function automatic void encode_step(input byte_req_t r);
		logic [7:0] b;
		if (r.req_type == REQ_LOAD) begin
			alphabet[r.table_index] = r.table_char;
			return;
		end
		b = r.data_byte;
		case (grp_pos)
			POS_ONE: begin
				push_char(alphabet[{carry[1:0], b[7:4]}], 1'b0);
				if (r.last_byte) begin
					push_char(alphabet[{b[3:0], 2'b00}], 1'b0);
					push_char(PAD_CHAR, 1'b1);
					grp_pos = POS_START;
					carry = 4'd0;
				end else begin
					carry = b[3:0];
					grp_pos = POS_TWO;
				end
			end
			POS_TWO: begin
				push_char(alphabet[{carry, b[7:6]}], 1'b0);
				push_char(alphabet[b[5:0]], r.last_byte);
				grp_pos = POS_START;
				carry = 4'd0;
			end
			default: begin
				push_char(alphabet[b[7:2]], 1'b0);
				if (r.last_byte) begin
					push_char(alphabet[{b[1:0], 4'b0000}], 1'b0);
					push_char(PAD_CHAR, 1'b0);
					push_char(PAD_CHAR, 1'b1);
					grp_pos = POS_START;
					carry = 4'd0;
				end else begin
					carry = {2'b00, b[1:0]};
					grp_pos = POS_ONE;
				end
			end
		endcase
	endfunction

	// idle mix: sender light / receiver heavy, then swapped, then none
	function automatic int sender_idle_pct();
		if (items_taken < total_items / 3)
			return 14;
		else if (items_taken < 2 * total_items / 3)
			return 49;
		return 0;
	endfunction

	function automatic int recv_stall_pct();
		if (items_taken < total_items / 3)
			return 49;
		else if (items_taken < 2 * total_items / 3)
			return 14;
		return 0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// driver: new transaction once the previous one is taken
	always @(negedge clk) begin
		byte_req_t nxt;
		if (arst_n) begin
			if (!byte_ch.valid || byte_taken) begin
				if (byte_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
					nxt = byte_queue.pop_front();
					byte_ch.valid       <= 1'b1;
					byte_ch.req_type    <= nxt.req_type;
					byte_ch.data_byte   <= nxt.data_byte;
					byte_ch.last_byte   <= nxt.last_byte;
					byte_ch.table_index <= nxt.table_index;
					byte_ch.table_char  <= nxt.table_char;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
			char_ch.ready <= ($urandom_range(99) >= recv_stall_pct());
		end
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		byte_req_t r;
		b64_char_t want;
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else begin
			byte_taken <= byte_ch.valid && byte_ch.ready;
			if (byte_ch.valid && byte_ch.ready) begin
				r.req_type    = byte_ch.req_type;
				r.data_byte   = byte_ch.data_byte;
				r.last_byte   = byte_ch.last_byte;
				r.table_index = byte_ch.table_index;
				r.table_char  = byte_ch.table_char;
				encode_step(r);
				items_taken++;
			end
			if (char_ch.valid && char_ch.ready) begin
				if (char_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected char %h last %b",
						char_ch.out_char, char_ch.out_last));
				end else begin
					want = char_queue.pop_front();
					if (char_ch.out_char !== want.ch)
						report_mismatch($sformatf("out_char %h, want %h",
							char_ch.out_char, want.ch));
					if (char_ch.out_last !== want.last)
						report_mismatch($sformatf("out_last %b, want %b",
							char_ch.out_last, want.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int n;
		int len;
		arst_n              = 1'b0;
		byte_ch.valid       = 1'b0;
		byte_ch.req_type    = REQ_DATA;
		byte_ch.data_byte   = 8'h00;
		byte_ch.last_byte   = 1'b0;
		byte_ch.table_index = 6'd0;
		byte_ch.table_char  = 8'h00;
		char_ch.ready       = 1'b0;
		grp_pos             = POS_START;
		carry               = 4'd0;
		items_taken         = 0;
		mismatches          = 0;
		cycle_count         = 0;
		foreach (alphabet[i])
			alphabet[i] = 8'h00;

		// full table first so no lookup ever hits an unwritten entry
		for (int i = 0; i < 64; i++)
			byte_queue.push_back(mk_load(6'(i), std_alphabet(i)));

		// one byte, two bytes, full group, group plus one
		byte_queue.push_back(mk_data(8'h4D, 1'b1));
		byte_queue.push_back(mk_data(8'h00, 1'b0));
		byte_queue.push_back(mk_data(8'hFF, 1'b1));
		byte_queue.push_back(mk_data(8'hFF, 1'b0));
		byte_queue.push_back(mk_data(8'hFF, 1'b0));
		byte_queue.push_back(mk_data(8'hFF, 1'b1));
		for (int i = 0; i < 4; i++)
			byte_queue.push_back(mk_data(8'h00, i == 3));
		// loads in the middle of a message, extreme entries and codes
		byte_queue.push_back(mk_data(8'hFC, 1'b0));
		byte_queue.push_back(mk_load(6'd63, 8'hFF));
		byte_queue.push_back(mk_load(6'd0, 8'h00));
		byte_queue.push_back(mk_data(8'h03, 1'b1));

		n = 0;
		while (n < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 10) begin
				byte_queue.push_back(mk_load(6'($urandom_range(63)), 8'($urandom_range(255))));
				n++;
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(99) < 10) begin
						byte_queue.push_back(mk_load(6'($urandom_range(63)),
							8'($urandom_range(255))));
						n++;
					end
					byte_queue.push_back(mk_data(8'($urandom_range(255)), i == len - 1));
					n++;
				end
			end
		end
		total_items = byte_queue.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() != 0 || byte_ch.valid || char_queue.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
